>>> hdl/dssa_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack shared array package
// Action and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dssa_pkg;

   // Widths of the word fields.
   localparam int unsigned DataWidth   = 32;
   localparam int unsigned ActionWidth = 3;
   localparam int unsigned StatusWidth = 2;

   // Operation codes carried by the request word.
   typedef enum logic [ActionWidth-1:0] {
      ACT_PUSH_ONE = 3'd0,
      ACT_POP_ONE  = 3'd1,
      ACT_DUMP_ONE = 3'd2,
      ACT_PUSH_TWO = 3'd3,
      ACT_POP_TWO  = 3'd4,
      ACT_DUMP_TWO = 3'd5
   } dssa_action_type;

   // Result status codes.
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } dssa_status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;       // Latch the operation and its top pointer.
      logic            stack_two;  // Operation targets the downward stack.
      logic            dump;       // Operation is a dump that walks the stack.
      logic            has_data;   // Result words carry a stored value.
      logic            push;       // Write the push value and grow the stack.
      logic            pop;        // Shrink the selected stack by one.
      logic            read;       // Read the store at the current pointer.
      logic            step;       // Move the dump pointer toward the bottom.
      dssa_status_type status;     // Status code of the result words.
   } dssa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;       // Both stacks together fill the store.
      logic one_empty;  // Upward stack holds nothing.
      logic two_empty;  // Downward stack holds nothing.
      logic last;       // The word being presented is the final one.
   } dssa_sts_type;

endpackage

>>> hdl/dssa_ctrl.sv
// ----------------------------------------------------------------------------
// Dual stack shared array controller
// Decodes each request word and sequences the store reads and the response
// handshake through a one-hot state machine.
// ----------------------------------------------------------------------------
module dssa_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dssa_pkg::ActionWidth-1:0]      req_action,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  dssa_pkg::dssa_sts_type                sts,
   output dssa_pkg::dssa_cmd_type                cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } dssa_state_type;

   dssa_state_type state_ff;
   dssa_state_type state_in;
   logic           sel_two;
   logic           sel_empty;

   // Requests are taken only while no operation is in progress.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

   // Stack selection and its emptiness for the incoming word.
   assign sel_two = (req_action == dssa_pkg::ACT_PUSH_TWO) ||
                    (req_action == dssa_pkg::ACT_POP_TWO)  ||
                    (req_action == dssa_pkg::ACT_DUMP_TWO);
   assign sel_empty = sel_two ? sts.two_empty : sts.one_empty;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.stack_two = sel_two;
      cmd.status    = dssa_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  dssa_pkg::ACT_PUSH_ONE, dssa_pkg::ACT_PUSH_TWO: begin
                     cmd.load   = 1'b1;
                     cmd.push   = !sts.full;
                     cmd.status = sts.full ? dssa_pkg::STATUS_FULL : dssa_pkg::STATUS_OK;
                     state_in   = ST_SEND;
                  end
                  dssa_pkg::ACT_POP_ONE, dssa_pkg::ACT_POP_TWO: begin
                     cmd.load = 1'b1;
                     if (sel_empty) begin
                        cmd.status = dssa_pkg::STATUS_EMPTY;
                        state_in   = ST_SEND;
                     end else begin
                        cmd.has_data = 1'b1;
                        cmd.pop      = 1'b1;
                        state_in     = ST_FETCH;
                     end
                  end
                  dssa_pkg::ACT_DUMP_ONE, dssa_pkg::ACT_DUMP_TWO: begin
                     cmd.load = 1'b1;
                     if (sel_empty) begin
                        cmd.status = dssa_pkg::STATUS_EMPTY;
                        state_in   = ST_SEND;
                     end else begin
                        cmd.has_data = 1'b1;
                        cmd.dump     = 1'b1;
                        state_in     = ST_FETCH;
                     end
                  end
                  default: begin
                     // Undefined operation codes are dropped without a response.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dssa_dp.sv
// ----------------------------------------------------------------------------
// Dual stack shared array datapath
// Holds the shared store, both stack counts, the walk pointer and the
// response word registers.
// ----------------------------------------------------------------------------
module dssa_dp #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dssa_pkg::dssa_cmd_type                cmd,
   input  logic signed [dssa_pkg::DataWidth-1:0] req_push_value,
   output dssa_pkg::dssa_sts_type                sts,
   output logic signed [dssa_pkg::DataWidth-1:0] rsp_out_value,
   output logic [dssa_pkg::StatusWidth-1:0]      rsp_status,
   output logic                                  rsp_last
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic signed [dssa_pkg::DataWidth-1:0] mem [DEPTH];
   logic signed [dssa_pkg::DataWidth-1:0] rd_data_ff;

   logic [CW-1:0]             one_count_ff;
   logic [CW-1:0]             one_count_in;
   logic [CW-1:0]             two_count_ff;
   logic [CW-1:0]             two_count_in;
   logic [AW-1:0]             ptr_ff;
   logic [AW-1:0]             ptr_in;
   logic                      two_sel_ff;
   logic                      dump_ff;
   logic                      has_data_ff;
   dssa_pkg::dssa_status_type status_ff;

   logic [CW:0]   total;
   logic [CW-1:0] top_wide;
   logic [CW-1:0] wr_wide;
   logic [AW-1:0] wr_addr;
   logic          at_end;

   // Fill level and addresses derived from the counts.
   assign total    = {1'b0, one_count_ff} + {1'b0, two_count_ff};
   assign top_wide = cmd.stack_two ? (CW'(DEPTH) - two_count_ff)
                                   : (one_count_ff - CW'(1));
   assign wr_wide  = cmd.stack_two ? (CW'(DEPTH - 1) - two_count_ff) : one_count_ff;
   assign wr_addr  = wr_wide[AW-1:0];

   // A dump ends at the bottom entry of its stack.
   assign at_end = two_sel_ff ? (ptr_ff == AW'(DEPTH - 1)) : (ptr_ff == '0);

   assign sts.full      = (total >= (CW + 1)'(DEPTH));
   assign sts.one_empty = (one_count_ff == '0);
   assign sts.two_empty = (two_count_ff == '0);
   assign sts.last      = !dump_ff || at_end;

   // Count updates for push and pop.
   always_comb begin
      one_count_in = one_count_ff;
      two_count_in = two_count_ff;
      if (cmd.push) begin
         if (cmd.stack_two) begin
            two_count_in = two_count_ff + CW'(1);
         end else begin
            one_count_in = one_count_ff + CW'(1);
         end
      end else if (cmd.pop) begin
         if (cmd.stack_two) begin
            two_count_in = two_count_ff - CW'(1);
         end else begin
            one_count_in = one_count_ff - CW'(1);
         end
      end
   end

   // Pointer load at the top, then a walk toward the bottom during a dump.
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = top_wide[AW-1:0];
      end else if (cmd.step) begin
         ptr_in = two_sel_ff ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_count_ff <= '0;
         two_count_ff <= '0;
         dump_ff      <= 1'b0;
      end else begin
         one_count_ff <= one_count_in;
         two_count_ff <= two_count_in;
         if (cmd.load) begin
            dump_ff <= cmd.dump;
         end
      end
   end

   // Operation and pointer registers.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         two_sel_ff  <= cmd.stack_two;
         has_data_ff <= cmd.has_data;
         status_ff   <= cmd.status;
      end
   end

   // Shared store with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= req_push_value;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   // Response word.
   assign rsp_out_value = has_data_ff ? rd_data_ff : '0;
   assign rsp_status    = status_ff;
   assign rsp_last      = sts.last;

endmodule

>>> hdl/dual_stack_shared_array.sv
// ----------------------------------------------------------------------------
// Dual stack shared array
// Two stacks in one store: stack one grows up from entry zero, stack two
// grows down from the last entry. Push, pop and dump on either stack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Word
//  req_      in         req_valid/req_stall  req_action, req_push_value
//  rsp_      out        rsp_valid/rsp_stall  rsp_out_value, rsp_status, rsp_last
//
//  A push, or any request that answers full or empty, is presented straight
//  from the idle state; a pop first makes a registered store read; a dump,
//  for each entry from top to bottom, makes the store read and presents it.
//  Reset clears both stack counts; the store itself is not cleared.
//  A stalled response holds its word and delays the next request by as much.
// ----------------------------------------------------------------------------
module dual_stack_shared_array #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dssa_pkg::ActionWidth-1:0]      req_action,
   input  logic signed [dssa_pkg::DataWidth-1:0] req_push_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dssa_pkg::DataWidth-1:0] rsp_out_value,
   output logic [dssa_pkg::StatusWidth-1:0]      rsp_status,
   output logic                                  rsp_last
);

   dssa_pkg::dssa_cmd_type cmd;
   dssa_pkg::dssa_sts_type sts;

   // Sequencing.
   dssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Store, counts and response registers.
   dssa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_push_value (req_push_value),
      .sts            (sts),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

>>> hdl/dssa_checker.sv
// ----------------------------------------------------------------------------
// Dual stack shared array checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dssa_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [dssa_pkg::ActionWidth-1:0]      req_action,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [dssa_pkg::DataWidth-1:0] rsp_out_value,
   input logic [dssa_pkg::StatusWidth-1:0]      rsp_status,
   input logic                                  rsp_last
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value) &&
      $stable(rsp_status) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // No request is taken while a response is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open while a response is pending");

   // Full and empty answers are single words with a zero value.
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dssa_pkg::STATUS_OK) |->
      rsp_last && (rsp_out_value == '0))
      else $error("full or empty response is not a single zero word");

   // A push is answered in the next cycle by a single zero word.
   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      ((req_action == dssa_pkg::ACT_PUSH_ONE) || (req_action == dssa_pkg::ACT_PUSH_TWO))
      |=> rsp_valid && rsp_last && (rsp_out_value == '0) &&
      (rsp_status != dssa_pkg::STATUS_EMPTY))
      else $error("push not answered by a single word");

endmodule

bind dual_stack_shared_array dssa_checker u_dssa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);
